// ===== sv/ipv4_longest_prefix_match_assert.svh =====
// assertion macros for the prefix match block
`ifndef IPV4_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define IPV4_LONGEST_PREFIX_MATCH_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define LPM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prefix match check failed");

// next-cycle implication
`define LPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prefix match check failed");

`endif

// ===== sv/lpm_pkg.sv =====
package lpm_pkg;

	localparam int PORT_W     = 8;
	localparam int IN_ADDR_W  = 32;
	localparam int IN_LEN_W   = 6;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// flags carried along the cell chain with each transaction
	typedef struct packed {
		logic mode;
		logic found;
		logic dup;
		logic have_free;
	} lpm_ctl_t;

endpackage

// ===== sv/lpm_if.sv =====
interface lpm_in_if;
	import lpm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [IN_ADDR_W-1:0] address;
	logic [IN_LEN_W-1:0]  prefix_length;
	logic [PORT_W-1:0]    port;

	modport source (output valid, mode, address, prefix_length, port, input ready);
	modport sink (input valid, mode, address, prefix_length, port, output ready);
endinterface

interface lpm_out_if;
	import lpm_pkg::*;
	logic              valid;
	logic              ready;
	logic              matched;
	logic [PORT_W-1:0] out_port;
	logic              status;

	modport source (output valid, matched, out_port, status, input ready);
	modport sink (input valid, matched, out_port, status, output ready);
endinterface

// ===== sv/ipv4_longest_prefix_match.sv =====
// IPv4 longest prefix match table. Each table entry lives in one cell of a chain
// of TABLE_ENTRIES cells; a transaction enters the first cell and moves one cell
// per clock while the chain is not held, and its result is shown on the result
// channel the cycle after it leaves the last cell. One item is in the chain at a
// time: a new transaction is taken in the cycle after the previous one leaves
// the chain, so none enters before the last one is through. The result register
// lets the next item enter while a finished result still waits; if that result
// is still not taken when the next item reaches the end, the chain holds.
// Lookups return the port of the longest stored prefix covering the address, a
// /0 entry acting as the default route. Inserts keep only the top prefix_length
// bits (saturated to ADDRESS_BITS), overwrite the port of an identical prefix in
// place, otherwise take the lowest free entry; status flags a full table.
// The table is empty after reset, with no clearing pass.
module ipv4_longest_prefix_match #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 32
) (
	input logic         clk,
	input logic         arst_n,
	lpm_in_if.sink      item,
	lpm_out_if.source   result
);
	import lpm_pkg::*;

	localparam int LEN_W = $clog2(ADDRESS_BITS + 1);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// chain taps: index 0 feeds the first cell, index TABLE_ENTRIES is the end
	logic                    ch_v         [0:TABLE_ENTRIES];
	lpm_ctl_t                ch_ctl       [0:TABLE_ENTRIES];
	logic [ADDRESS_BITS-1:0] ch_addr      [0:TABLE_ENTRIES];
	logic [LEN_W-1:0]        ch_len       [0:TABLE_ENTRIES];
	logic [PORT_W-1:0]       ch_port      [0:TABLE_ENTRIES];
	logic [LEN_W-1:0]        ch_best_len  [0:TABLE_ENTRIES];
	logic [PORT_W-1:0]       ch_best_port [0:TABLE_ENTRIES];
	logic [IDX_W-1:0]        ch_free_idx  [0:TABLE_ENTRIES];

	logic                    busy_q;
	logic                    accept;
	logic                    adv;
	logic                    end_v;
	logic                    end_take;
	lpm_ctl_t                end_ctl;
	lpm_ctl_t                ctl_in;
	logic                    wr_en;

	logic [IN_LEN_W:0]       len_ext;
	logic [LEN_W-1:0]        len_in;
	logic [ADDRESS_BITS-1:0] addr_raw;
	logic [ADDRESS_BITS-1:0] in_mask;

	logic                    res_valid_q;
	logic                    res_matched_q;
	logic [PORT_W-1:0]       res_port_q;
	logic                    res_status_q;

	logic [TABLE_ENTRIES:0]  chain_valids;

	// one transaction in flight; ready drops from accept until it leaves the chain
	assign item.ready = !busy_q;
	assign accept     = item.valid && !busy_q;

	// saturate the prefix length and keep only the address bits the table holds
	assign len_ext  = {1'b0, item.prefix_length};
	assign len_in   = (len_ext > (IN_LEN_W + 1)'(ADDRESS_BITS)) ?
		LEN_W'(ADDRESS_BITS) : LEN_W'(len_ext);
	assign addr_raw = ADDRESS_BITS'(item.address);
	assign in_mask  = ~({ADDRESS_BITS{1'b1}} >> len_in);

	// fresh transaction flags, nothing found yet
	always_comb begin
		ctl_in      = '0;
		ctl_in.mode = item.mode;
	end

	// first tap
	assign ch_v[0]         = accept;
	assign ch_ctl[0]       = ctl_in;
	assign ch_addr[0]      = (item.mode == MODE_INSERT) ? (addr_raw & in_mask) : addr_raw;
	assign ch_len[0]       = len_in;
	assign ch_port[0]      = item.port;
	assign ch_best_len[0]  = '0;
	assign ch_best_port[0] = '0;
	assign ch_free_idx[0]  = '0;

	// end of chain; hold the whole chain if the previous result is still unread
	assign end_v    = ch_v[TABLE_ENTRIES];
	assign end_ctl  = ch_ctl[TABLE_ENTRIES];
	assign adv      = !(end_v && res_valid_q && !result.ready);
	assign end_take = end_v && adv;

	// new prefix goes to the lowest free entry found on the way down the chain
	assign wr_en = end_take && (end_ctl.mode == MODE_INSERT) && !end_ctl.dup &&
		end_ctl.have_free;

	for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
		lpm_cell #(
			.ADDRESS_BITS(ADDRESS_BITS),
			.LEN_W       (LEN_W),
			.IDX_W       (IDX_W),
			.CELL_INDEX  (gi)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.adv          (adv),
			.tok_v        (ch_v[gi]),
			.tok_ctl      (ch_ctl[gi]),
			.tok_addr     (ch_addr[gi]),
			.tok_len      (ch_len[gi]),
			.tok_port     (ch_port[gi]),
			.tok_best_len (ch_best_len[gi]),
			.tok_best_port(ch_best_port[gi]),
			.tok_free_idx (ch_free_idx[gi]),
			.nxt_v        (ch_v[gi+1]),
			.nxt_ctl      (ch_ctl[gi+1]),
			.nxt_addr     (ch_addr[gi+1]),
			.nxt_len      (ch_len[gi+1]),
			.nxt_port     (ch_port[gi+1]),
			.nxt_best_len (ch_best_len[gi+1]),
			.nxt_best_port(ch_best_port[gi+1]),
			.nxt_free_idx (ch_free_idx[gi+1]),
			.wr_en        (wr_en),
			.wr_idx       (ch_free_idx[TABLE_ENTRIES]),
			.wr_prefix    (ch_addr[TABLE_ENTRIES]),
			.wr_len       (ch_len[TABLE_ENTRIES]),
			.wr_port      (ch_port[TABLE_ENTRIES])
		);
	end

	// busy from accept until the transaction leaves the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (end_take) begin
				busy_q <= 1'b0;
			end
			if (end_take) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register: lookups report the best match, inserts only the full flag
	always_ff @(posedge clk) begin
		if (end_take) begin
			if (end_ctl.mode == MODE_INSERT) begin
				res_matched_q <= 1'b0;
				res_port_q    <= '0;
				res_status_q  <= (!end_ctl.dup && !end_ctl.have_free) ? STATUS_FULL : STATUS_OK;
			end else begin
				res_matched_q <= end_ctl.found;
				res_port_q    <= end_ctl.found ? ch_best_port[TABLE_ENTRIES] : '0;
				res_status_q  <= STATUS_OK;
			end
		end
	end

	assign result.valid    = res_valid_q;
	assign result.matched  = res_matched_q;
	assign result.out_port = res_port_q;
	assign result.status   = res_status_q;

	always_comb begin
		for (int i = 0; i <= TABLE_ENTRIES; i++) begin
			chain_valids[i] = ch_v[i];
		end
	end

`include "ipv4_longest_prefix_match_assert.svh"

	// a taken transaction keeps the block busy for the next cycle
	`LPM_ASSERT_NEXT(a_busy_after_accept, accept, busy_q)
	// at most one transaction anywhere in the chain
	`LPM_ASSERT_NOW(a_single_in_chain, 1'b1, $onehot0(chain_valids))
	// nothing reaches the end of the chain unless the block is busy
	`LPM_ASSERT_NOW(a_end_needs_busy, end_v, busy_q)
	// a refused insert never reports a match
	`LPM_ASSERT_NOW(a_full_no_match, res_valid_q && (res_status_q == STATUS_FULL), !res_matched_q)

endmodule

// ===== sv/lpm_cell.sv =====
module lpm_cell #(
	parameter int ADDRESS_BITS = 32,
	parameter int LEN_W        = 6,
	parameter int IDX_W        = 6,
	parameter int CELL_INDEX   = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      tok_v,
	input  lpm_pkg::lpm_ctl_t         tok_ctl,
	input  logic [ADDRESS_BITS-1:0]   tok_addr,
	input  logic [LEN_W-1:0]          tok_len,
	input  logic [lpm_pkg::PORT_W-1:0] tok_port,
	input  logic [LEN_W-1:0]          tok_best_len,
	input  logic [lpm_pkg::PORT_W-1:0] tok_best_port,
	input  logic [IDX_W-1:0]          tok_free_idx,
	output logic                      nxt_v,
	output lpm_pkg::lpm_ctl_t         nxt_ctl,
	output logic [ADDRESS_BITS-1:0]   nxt_addr,
	output logic [LEN_W-1:0]          nxt_len,
	output logic [lpm_pkg::PORT_W-1:0] nxt_port,
	output logic [LEN_W-1:0]          nxt_best_len,
	output logic [lpm_pkg::PORT_W-1:0] nxt_best_port,
	output logic [IDX_W-1:0]          nxt_free_idx,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [ADDRESS_BITS-1:0]   wr_prefix,
	input  logic [LEN_W-1:0]          wr_len,
	input  logic [lpm_pkg::PORT_W-1:0] wr_port
);
	import lpm_pkg::*;

	logic                    valid_q;
	logic [ADDRESS_BITS-1:0] prefix_q;
	logic [LEN_W-1:0]        len_q;
	logic [PORT_W-1:0]       port_q;

	logic [ADDRESS_BITS-1:0] entry_mask;
	logic                    hit;
	logic                    same;
	logic                    wr_here;
	lpm_ctl_t                ctl_d;
	logic [LEN_W-1:0]        best_len_d;
	logic [PORT_W-1:0]       best_port_d;
	logic [IDX_W-1:0]        free_idx_d;

	logic                    v_s1;
	lpm_ctl_t                ctl_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic [LEN_W-1:0]        len_s1;
	logic [PORT_W-1:0]       port_s1;
	logic [LEN_W-1:0]        best_len_s1;
	logic [PORT_W-1:0]       best_port_s1;
	logic [IDX_W-1:0]        free_idx_s1;

	// stored prefix is already masked, so only the lookup address needs masking
	assign entry_mask = ~({ADDRESS_BITS{1'b1}} >> len_q);
	assign hit        = valid_q && ((tok_addr & entry_mask) == prefix_q);
	assign same       = valid_q && (len_q == tok_len) && (prefix_q == tok_addr);
	assign wr_here    = wr_en && (wr_idx == IDX_W'(CELL_INDEX));

	always_comb begin
		ctl_d       = tok_ctl;
		best_len_d  = tok_best_len;
		best_port_d = tok_best_port;
		free_idx_d  = tok_free_idx;
		if (tok_ctl.mode == MODE_INSERT) begin
			if (same) begin
				ctl_d.dup = 1'b1;
			end
			if (!valid_q && !tok_ctl.have_free) begin
				ctl_d.have_free = 1'b1;
				free_idx_d      = IDX_W'(CELL_INDEX);
			end
		end else if (hit && (!tok_ctl.found || (len_q > tok_best_len))) begin
			ctl_d.found = 1'b1;
			best_len_d  = len_q;
			best_port_d = port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			if (wr_here) begin
				valid_q <= 1'b1;
			end
			if (adv) begin
				v_s1 <= tok_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			prefix_q <= wr_prefix;
			len_q    <= wr_len;
			port_q   <= wr_port;
		end else if (adv && tok_v && (tok_ctl.mode == MODE_INSERT) && same) begin
			port_q <= tok_port;
		end
		if (adv) begin
			ctl_s1       <= ctl_d;
			addr_s1      <= tok_addr;
			len_s1       <= tok_len;
			port_s1      <= tok_port;
			best_len_s1  <= best_len_d;
			best_port_s1 <= best_port_d;
			free_idx_s1  <= free_idx_d;
		end
	end

	assign nxt_v         = v_s1;
	assign nxt_ctl       = ctl_s1;
	assign nxt_addr      = addr_s1;
	assign nxt_len       = len_s1;
	assign nxt_port      = port_s1;
	assign nxt_best_len  = best_len_s1;
	assign nxt_best_port = best_port_s1;
	assign nxt_free_idx  = free_idx_s1;

endmodule

// ===== sim/ipv4_longest_prefix_match_tb.sv =====
`timescale 1ns / 100ps

// self-checking bench for the longest prefix match table
module ipv4_longest_prefix_match_tb;
	import lpm_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int ADDRESS_BITS  = 32;
	localparam int TOTAL_ITEMS   = 1550;
	localparam int BASE_COUNT    = 12;
	// sender waits for an empty pipe once this many transactions are in
	localparam int DRAIN_AT      = 700;
	// receiver holds off for a long stretch once this many results are out
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	// window of results with ready held high throughout
	localparam int QUIET_FROM    = 900;
	localparam int QUIET_TO      = 1100;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int PRINT_CAP     = 40;

	// one request: lookup or insert
	typedef struct packed {
		logic                 mode;
		logic [IN_ADDR_W-1:0] address;
		logic [IN_LEN_W-1:0]  prefix_length;
		logic [PORT_W-1:0]    port;
	} route_req_t;

	// one answer from the table
	typedef struct packed {
		logic              matched;
		logic [PORT_W-1:0] out_port;
		logic              status;
	} route_rsp_t;

	logic clk;
	logic arst_n;

	lpm_in_if  item_ch ();
	lpm_out_if result_ch ();

	ipv4_longest_prefix_match #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	// shadow copy of the routing table
	logic                 rt_valid  [TABLE_ENTRIES];
	logic [IN_ADDR_W-1:0] rt_prefix [TABLE_ENTRIES];
	int unsigned          rt_len    [TABLE_ENTRIES];
	logic [PORT_W-1:0]    rt_port   [TABLE_ENTRIES];

	route_req_t route_requests_q[$];   // waiting to be offered
	route_rsp_t route_answers_q[$];    // expected, oldest first
	route_req_t offered;               // transaction currently on the input channel
	logic [IN_ADDR_W-1:0] route_bases[BASE_COUNT];

	int accepted_cnt;
	int results_seen;
	int mismatches;
	int cycle_cnt;
	int gap_left;
	int stall_left;
	bit hold_done;

	// run statistics
	int n_hits, n_misses, n_added, n_overwritten, n_refused;

	// keeps the top len bits; a shift by the full width leaves nothing, so /0 masks all
	function automatic logic [IN_ADDR_W-1:0] len_mask(int unsigned len);
		logic [IN_ADDR_W-1:0] ones;
		ones = '1;
		return ones << (ADDRESS_BITS - len);
	endfunction

	// applies one request to the shadow table and returns the expected answer
	function automatic route_rsp_t route_table_apply(route_req_t req);
		route_rsp_t           rsp;
		int unsigned          len;
		logic [IN_ADDR_W-1:0] pfx;
		int                   free_slot;
		bit                   found;
		int unsigned          best_len;
		rsp = '0;
		rsp.status = STATUS_OK;
		// overlong prefixes saturate to the address width
		len = (req.prefix_length > ADDRESS_BITS) ? ADDRESS_BITS : req.prefix_length;
		if (req.mode == MODE_INSERT) begin
			// stray bits below the prefix are dropped
			pfx = req.address & len_mask(len);
			free_slot = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (rt_valid[i]) begin
					if (rt_len[i] == len && rt_prefix[i] == pfx) begin
						// same prefix already stored: port is overwritten in place
						rt_port[i] = req.port;
						n_overwritten++;
						return rsp;
					end
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (free_slot < 0) begin
				rsp.status = STATUS_FULL;
				n_refused++;
			end else begin
				rt_valid[free_slot]  = 1'b1;
				rt_prefix[free_slot] = pfx;
				rt_len[free_slot]    = len;
				rt_port[free_slot]   = req.port;
				n_added++;
			end
		end else begin
			// longest match wins, a /0 entry covers every address
			found = 1'b0;
			best_len = 0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (rt_valid[i] && (req.address & len_mask(rt_len[i])) == rt_prefix[i]
						&& (!found || rt_len[i] > best_len)) begin
					found = 1'b1;
					best_len = rt_len[i];
					rsp.out_port = rt_port[i];
				end
			end
			rsp.matched = found;
			if (found) begin
				n_hits++;
			end else begin
				n_misses++;
			end
		end
		return rsp;
	endfunction

	function automatic void queue_request(logic mode, logic [IN_ADDR_W-1:0] address,
			logic [IN_LEN_W-1:0] prefix_length, logic [PORT_W-1:0] port);
		route_req_t req;
		req.mode          = mode;
		req.address       = address;
		req.prefix_length = prefix_length;
		req.port          = port;
		route_requests_q.push_back(req);
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch at cycle %0d, result %0d: %s", cycle_cnt, results_seen, what);
		end
		mismatches++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				route_answers_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// driver: offers queued requests with random gaps, predicts on each transaction
	always @(posedge clk) begin
		logic fire;
		logic offer;
		if (arst_n) begin
			fire = item_ch.valid && item_ch.ready;
			if (fire) begin
				route_answers_q.push_back(route_table_apply(offered));
				accepted_cnt++;
				// half back-to-back, most of the rest short gaps, a few long ones
				case ($urandom_range(0, 99)) inside
					[0:49]:  gap_left = 0;
					[50:91]: gap_left = $urandom_range(1, 4);
					default: gap_left = $urandom_range(20, 80);
				endcase
			end
			if (fire || !item_ch.valid) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (route_requests_q.size() > 0
						&& !(accepted_cnt == DRAIN_AT && route_answers_q.size() != 0)) begin
					// at the drain point the sender waits for every answer first
					offered = route_requests_q.pop_front();
					offer = 1'b1;
					item_ch.mode          <= offered.mode;
					item_ch.address       <= offered.address;
					item_ch.prefix_length <= offered.prefix_length;
					item_ch.port          <= offered.port;
				end
				item_ch.valid <= offer;
			end
		end
	end

	// monitor: checks each result transaction and paces result ready
	always @(posedge clk) begin
		route_rsp_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (route_answers_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = route_answers_q.pop_front();
					if (result_ch.matched !== want.matched) begin
						report_mismatch($sformatf("matched %b, expected %b",
							result_ch.matched, want.matched));
					end
					if (result_ch.out_port !== want.out_port) begin
						report_mismatch($sformatf("out_port %0d, expected %0d",
							result_ch.out_port, want.out_port));
					end
					if (result_ch.status !== want.status) begin
						report_mismatch($sformatf("status %b, expected %b",
							result_ch.status, want.status));
					end
				end
			end
			// one long hold-off so the chain holds and stalls the input side
			if (results_seen == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (results_seen < QUIET_FROM || results_seen > QUIET_TO) begin
					case ($urandom_range(0, 99)) inside
						[0:5]:   stall_left = $urandom_range(1, 5);
						6:       stall_left = $urandom_range(30, 150);
						default: stall_left = 0;
					endcase
				end
				result_ch.ready <= (stall_left == 0);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int                   n_random;
		int                   pick;
		logic [IN_ADDR_W-1:0] addr;
		int unsigned          len;
		logic [IN_LEN_W-1:0]  len_field;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_LOOKUP;
		item_ch.address = '0;
		item_ch.prefix_length = '0;
		item_ch.port = '0;
		result_ch.ready = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			rt_valid[i] = 1'b0;
		end

		// directed: empty table, nesting, default route, host routes, overwrites
		queue_request(MODE_LOOKUP, 32'h0000_0000, 6'h3F, 8'hFF);  // empty table misses
		queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 6'h00, 8'h00);
		queue_request(MODE_INSERT, 32'h0A12_3456, 6'd8,  8'h01);  // stray bits below /8
		queue_request(MODE_LOOKUP, 32'h0AFF_FFFF, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'h0A12_0000, 6'd16, 8'h02);
		queue_request(MODE_INSERT, 32'h0A12_34FF, 6'd24, 8'h03);
		queue_request(MODE_LOOKUP, 32'h0A12_34FF, 6'd32, 8'hA5);  // deepest of three nested
		queue_request(MODE_LOOKUP, 32'h0A12_FF00, 6'd7,  8'h5A);
		queue_request(MODE_LOOKUP, 32'h0B00_0000, 6'd1,  8'h01);  // no match yet
		queue_request(MODE_INSERT, 32'hDEAD_BEEF, 6'd0,  8'hFF);  // default route
		queue_request(MODE_LOOKUP, 32'h0B00_0000, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h80);
		queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'hC0A8_0101, 6'd63, 8'h55);  // overlong length
		queue_request(MODE_INSERT, 32'hC0A8_0101, 6'd33, 8'h66);  // same /32, overwrite
		queue_request(MODE_LOOKUP, 32'hC0A8_0101, 6'd16, 8'h00);
		queue_request(MODE_INSERT, 32'h0AFF_FFFF, 6'd8,  8'h7E);  // same /8, other stray bits
		queue_request(MODE_LOOKUP, 32'h0A00_0001, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'h0123_4567, 6'd0,  8'h00);  // default route to port 0
		queue_request(MODE_LOOKUP, 32'h0102_0304, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'h0000_0000, 6'd32, 8'hAA);
		queue_request(MODE_LOOKUP, 32'h0000_0000, 6'd0,  8'h00);
		queue_request(MODE_INSERT, 32'h8000_0000, 6'd1,  8'h11);
		queue_request(MODE_LOOKUP, 32'h8000_0001, 6'd0,  8'h00);

		// random part draws most prefixes from a few bases so lookups hit nested
		// routes, inserts repeat and the table eventually fills up
		for (int i = 0; i < BASE_COUNT; i++) begin
			route_bases[i] = $urandom;
		end
		n_random = TOTAL_ITEMS - route_requests_q.size();
		for (int n = 0; n < n_random; n++) begin
			pick = $urandom_range(0, BASE_COUNT - 1);
			if ($urandom_range(0, 99) < 30) begin
				if ($urandom_range(0, 9) == 0) begin
					len_field = IN_LEN_W'($urandom_range(33, 63));
				end else begin
					len_field = IN_LEN_W'($urandom_range(0, 32));
				end
				len = (len_field > ADDRESS_BITS) ? ADDRESS_BITS : len_field;
				if ($urandom_range(0, 99) < 15) begin
					addr = $urandom;
				end else begin
					addr = route_bases[pick] ^ ($urandom & ~len_mask(len));
				end
				queue_request(MODE_INSERT, addr, len_field, PORT_W'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 99) < 70) begin
					addr = route_bases[pick] ^ ($urandom >> $urandom_range(0, 32));
				end else begin
					addr = $urandom;
				end
				queue_request(MODE_LOOKUP, addr, IN_LEN_W'($urandom_range(0, 63)),
					PORT_W'($urandom_range(0, 255)));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < TOTAL_ITEMS) @(posedge clk);
		while (route_answers_q.size() != 0) @(posedge clk);
		// one more pass through the chain to catch stray results
		repeat (TABLE_ENTRIES + 8) @(posedge clk);

		$display("covered %0d lookups (%0d hit, %0d missed) in %0d cycles", n_hits + n_misses,
			n_hits, n_misses, cycle_cnt);
		$display("covered %0d inserts: %0d added, %0d overwritten, %0d refused on a full table",
			n_added + n_overwritten + n_refused, n_added, n_overwritten, n_refused);
		if (mismatches == 0 && route_answers_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpm_pkg.sv
sv/lpm_if.sv
sv/lpm_cell.sv
sv/ipv4_longest_prefix_match.sv
sim/ipv4_longest_prefix_match_tb.sv
